/* design/ptw_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ptw_pkg;

  // Store geometry
  localparam int TABLE_WORDS_DEF = 4096;
  localparam int VA_W            = 48;
  localparam int PA_W            = 52;
  localparam int PTE_W           = 64;
  localparam int IDX_W           = 12;
  localparam int LVL_IDX_W       = 9;
  localparam int PFN_W           = PA_W - 12;
  localparam int WORD_W          = PFN_W + LVL_IDX_W;

  // Item kinds
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_XLATE = 1'b1;

  // Entry flag positions
  localparam int BIT_PRESENT = 0;
  localparam int BIT_LARGE   = 7;

  // Walk levels
  localparam logic [1:0] LVL_PML4 = 2'd0;
  localparam logic [1:0] LVL_PDPT = 2'd1;
  localparam logic [1:0] LVL_PD   = 2'd2;
  localparam logic [1:0] LVL_PT   = 2'd3;

  typedef struct packed {
    logic              func;
    logic [IDX_W-1:0]  entry_index;
    logic [PTE_W-1:0]  entry_value;
    logic [VA_W-1:0]   virt_addr;
  } in_item_t;

  typedef struct packed {
    logic [PA_W-1:0] phys_addr;
    logic            valid_res;
    logic            large_page;
  } out_item_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

  // Nine-bit table index of a virtual address at a given level.
  function automatic logic [LVL_IDX_W-1:0] va_index(input logic [VA_W-1:0] va,
                                                     input logic [1:0] lvl);
    logic [LVL_IDX_W-1:0] idx;
    unique case (lvl)
      LVL_PML4: idx = va[47:39];
      LVL_PDPT: idx = va[38:30];
      LVL_PD:   idx = va[29:21];
      LVL_PT:   idx = va[20:12];
    endcase
    return idx;
  endfunction

endpackage

`default_nettype wire

/* design/ptw_table_mem.sv */
`timescale 1ns / 1ps
`default_nettype none

module ptw_table_mem
  import ptw_pkg::*;
#(
  parameter int TABLE_WORDS = TABLE_WORDS_DEF,
  localparam int AW = $clog2(TABLE_WORDS)
) (
  input  wire logic             clk,
  input  wire mem_ctl_t         mem_ctl,
  input  wire logic [AW-1:0]    mem_addr,
  input  wire logic [PTE_W-1:0] mem_wdata,
  output logic [PTE_W-1:0]      rd_data_r
);

  logic [PTE_W-1:0] tbl_mem [TABLE_WORDS];

  // Single port, registered read.
  always_ff @(posedge clk) begin
    if (mem_ctl.wr_en) begin
      tbl_mem[mem_addr] <= mem_wdata;
    end
    if (mem_ctl.rd_en) begin
      rd_data_r <= tbl_mem[mem_addr];
    end
  end

endmodule

`default_nettype wire

/* design/ptw_walk_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module ptw_walk_ctrl
  import ptw_pkg::*;
#(
  parameter int TABLE_WORDS = TABLE_WORDS_DEF,
  localparam int AW = $clog2(TABLE_WORDS)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire in_item_t         in_data,
  input  wire logic [PFN_W-1:0] root_pfn,
  output logic                  busy,
  output mem_ctl_t              mem_ctl,
  output logic [AW-1:0]         mem_addr,
  input  wire logic [PTE_W-1:0] mem_rdata,
  output logic                  res_valid,
  output out_item_t             res_data
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WALK = 1'b1;

  logic            state_r, state_nxt;
  logic [1:0]      lvl_r, lvl_nxt;
  logic [VA_W-1:0] va_r, va_nxt;
  logic            rd_ok_r, rd_ok_nxt;

  logic [PFN_W-1:0]  walk_pfn;
  logic [VA_W-1:0]   walk_va;
  logic [1:0]        walk_lvl;
  logic [WORD_W-1:0] walk_word;
  logic              walk_ok;
  logic              wr_ok;

  assign busy      = (state_r == ST_WALK);
  assign walk_word = {walk_pfn, va_index(walk_va, walk_lvl)};
  assign walk_ok   = walk_word < WORD_W'(TABLE_WORDS);
  assign wr_ok     = 32'(in_data.entry_index) < 32'(TABLE_WORDS);

  // Table and level of the next read: the root at accept, the entry just read while walking.
  always_comb begin
    walk_pfn = root_pfn;
    walk_va  = in_data.virt_addr;
    walk_lvl = LVL_PML4;
    if (state_r == ST_WALK) begin
      walk_va  = va_r;
      walk_pfn = mem_rdata[PA_W-1:12];
      walk_lvl = lvl_r + 2'd1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    lvl_nxt   = lvl_r;
    va_nxt    = va_r;
    rd_ok_nxt = rd_ok_r;
    mem_ctl   = '0;
    mem_addr  = walk_word[AW-1:0];
    res_valid = 1'b0;
    res_data  = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_data.func == FUNC_WRITE) begin
            mem_addr      = AW'(in_data.entry_index);
            mem_ctl.wr_en = wr_ok;
          end else begin
            // Issue the top-level read in the accept cycle.
            mem_ctl.rd_en = walk_ok;
            rd_ok_nxt     = walk_ok;
            va_nxt        = in_data.virt_addr;
            lvl_nxt       = LVL_PML4;
            state_nxt     = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        priority if (!rd_ok_r || !mem_rdata[BIT_PRESENT]) begin
          res_valid = 1'b1;
          state_nxt = ST_IDLE;
        end else if (lvl_r == LVL_PD && mem_rdata[BIT_LARGE]) begin
          res_valid           = 1'b1;
          res_data.phys_addr  = {mem_rdata[PA_W-1:21], va_r[20:0]};
          res_data.valid_res  = 1'b1;
          res_data.large_page = 1'b1;
          state_nxt           = ST_IDLE;
        end else if (lvl_r == LVL_PT) begin
          res_valid          = 1'b1;
          res_data.phys_addr = {mem_rdata[PA_W-1:12], va_r[11:0]};
          res_data.valid_res = 1'b1;
          state_nxt          = ST_IDLE;
        end else begin
          // Chain straight into the next level's read.
          mem_ctl.rd_en = walk_ok;
          rd_ok_nxt     = walk_ok;
          lvl_nxt       = walk_lvl;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      lvl_r   <= LVL_PML4;
      rd_ok_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      lvl_r   <= lvl_nxt;
      rd_ok_r <= rd_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    va_r <= va_nxt;
  end

endmodule

`default_nettype wire

/* design/page_table_walker.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Ports                                  | Handshake
// ---------+----------------------------------------+---------------------------------
// input    | start, busy, in_data (in_item_t)       | taken when start && !busy
// result   | out_valid, out_data (out_item_t)       | one-cycle strobe, no back-pressure
// config   | cfg_valid, cfg_ready, cfg_data (52b)   | written when cfg_valid && cfg_ready
//
// A write transaction stores its entry in the accept cycle and leaves busy low.
// A translate transaction takes one table read per level, chained back to back
// through the single-port table memory (registered read): busy stays high while
// it walks, and the result strobes in the cycle after the last check.
// Faults (not present, or an entry outside the store) end the walk early.
// Reset is synchronous on rst_n and clears control and the root base; the table
// memory is not cleared. The receiver cannot stall, so results never wait.

module page_table_walker
  import ptw_pkg::*;
#(
  parameter int TABLE_WORDS = TABLE_WORDS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  output logic                 busy,
  input  wire in_item_t        in_data,
  output logic                 out_valid,
  output out_item_t            out_data,
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire logic [PA_W-1:0] cfg_data
);

  localparam int AW = $clog2(TABLE_WORDS);

  logic [PA_W-1:0]  root_base_r;
  logic             out_valid_r;
  out_item_t        out_data_r;
  mem_ctl_t         mem_ctl;
  logic [AW-1:0]    mem_addr;
  logic [PTE_W-1:0] mem_rdata;
  logic             res_valid;
  out_item_t        res_data;

  // The root base is sampled only at accept, so writes are always safe.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_base_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      root_base_r <= cfg_data;
    end
  end

  ptw_walk_ctrl #(
    .TABLE_WORDS (TABLE_WORDS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .root_pfn  (root_base_r[PA_W-1:12]),
    .busy      (busy),
    .mem_ctl   (mem_ctl),
    .mem_addr  (mem_addr),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res_data  (res_data)
  );

  ptw_table_mem #(
    .TABLE_WORDS (TABLE_WORDS)
  ) u_mem (
    .clk       (clk),
    .mem_ctl   (mem_ctl),
    .mem_addr  (mem_addr),
    .mem_wdata (in_data.entry_value),
    .rd_data_r (mem_rdata)
  );

  // Register the result; hold the strobe for exactly one cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  a_no_back_to_back_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobes on consecutive cycles");

  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.valid_res) |-> (out_data.phys_addr == '0 && !out_data.large_page))
    else $error("fault result carries nonzero fields");

  a_result_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without a walk in progress");

  a_xlate_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.func == FUNC_XLATE) |=> busy)
    else $error("translate accepted without starting a walk");
`endif

endmodule

`default_nettype wire

/* sim/page_table_walker_test.sv */
`timescale 1ns / 1ps

// Self-checking bench for the four-level page table walker.
// A local predictor mirrors the table memory and the root base and works out
// the expected result of every accepted translate transaction. Words are only
// ever read after being written: before a translate goes out, any unwritten
// word on its walk path is filled with a fresh entry first.

module page_table_walker_test;
  import ptw_pkg::*;

  localparam int         WATCHDOG_LIMIT = 1000;
  localparam int         SETTLE_CYCLES  = 8;
  localparam int         PML4_SHIFT     = 39;
  localparam int         MAX_PRINTS     = 30;
  localparam logic [63:0] FRAME_4K      = 64'h000F_FFFF_FFFF_F000;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_data;
  logic      out_valid;
  out_item_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [PA_W-1:0] cfg_data;

  page_table_walker uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  // Mirror of the block: table contents, which words hold defined data, root.
  logic [PTE_W-1:0] tbl_mem [TABLE_WORDS_DEF];
  bit               written [TABLE_WORDS_DEF];
  logic [PA_W-1:0]  root_base;

  out_item_t   expected_xlat[$];
  int          idle_pct;
  int          errors;
  int          n_items, n_writes, n_mapped, n_large, n_faults, n_roots;
  logic [VA_W-1:0] last_va;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Log one mismatch line (up to a cap) and count it.
  task automatic flag_error(input string what, input logic [63:0] got,
                            input logic [63:0] want);
    if (errors < MAX_PRINTS)
      $display("tb: mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
    errors++;
  endtask

  // Walk the mirrored tables for va. Returns the word index of the first
  // unwritten word the walk would read (with its level), or -1 when the walk
  // is fully defined, in which case res holds the translation.
  function automatic int walk_table(input logic [VA_W-1:0] va, output out_item_t res,
                                    output int need_lvl);
    logic [63:0]      base;
    logic [63:0]      word;
    logic [PTE_W-1:0] pte;
    int               lvl;
    int               sh;
    res      = '0;
    need_lvl = 0;
    base     = {{(64-PA_W){1'b0}}, root_base} & FRAME_4K;
    for (lvl = 0; lvl < 4; lvl++) begin
      sh   = PML4_SHIFT - LVL_IDX_W * lvl;
      word = (base + (64'(va[sh +: LVL_IDX_W]) << 3)) >> 3;
      // Entry outside the store: fault.
      if (word >= 64'(TABLE_WORDS_DEF)) return -1;
      if (!written[word]) begin
        need_lvl = lvl;
        return int'(word);
      end
      pte = tbl_mem[word];
      if (!pte[BIT_PRESENT]) return -1;
      // Large bit only counts at the third level; above it the entry is a pointer.
      if (2'(lvl) == LVL_PD && pte[BIT_LARGE]) begin
        res.phys_addr  = {pte[PA_W-1:21], va[20:0]};
        res.valid_res  = 1'b1;
        res.large_page = 1'b1;
        return -1;
      end
      base = pte & FRAME_4K;
    end
    res.phys_addr = {base[PA_W-1:12], va[11:0]};
    res.valid_res = 1'b1;
    return -1;
  endfunction

  // Update the mirror for one accepted transaction and queue its result.
  task automatic predict(input in_item_t item);
    out_item_t res;
    int        lvl;
    n_items++;
    if (item.func == FUNC_WRITE) begin
      if (int'(item.entry_index) < TABLE_WORDS_DEF) begin
        tbl_mem[item.entry_index] = item.entry_value;
        written[item.entry_index] = 1'b1;
      end
      n_writes++;
    end else begin
      void'(walk_table(item.virt_addr, res, lvl));
      expected_xlat.push_back(res);
      if (!res.valid_res) n_faults++;
      else if (res.large_page) n_large++;
      else n_mapped++;
    end
  endtask

  function automatic in_item_t write_item(input logic [IDX_W-1:0] idx,
                                          input logic [PTE_W-1:0] value);
    in_item_t item;
    item.func        = FUNC_WRITE;
    item.entry_index = idx;
    item.entry_value = value;
    item.virt_addr   = VA_W'({$urandom, $urandom});
    return item;
  endfunction

  function automatic in_item_t xlate_item(input logic [VA_W-1:0] va);
    in_item_t item;
    item.func        = FUNC_XLATE;
    item.entry_index = IDX_W'($urandom);
    item.entry_value = {$urandom, $urandom};
    item.virt_addr   = va;
    return item;
  endfunction

  // Fresh entry for a given level: mostly pointers that stay in the store,
  // some 2 MiB pages at the third level, random frames at the leaf, and a
  // share of not-present and out-of-store entries.
  function automatic logic [PTE_W-1:0] make_entry(input int lvl);
    logic [PTE_W-1:0] v;
    int               pick;
    v    = {$urandom, $urandom};
    pick = $urandom_range(99);
    if (2'(lvl) == LVL_PT) begin
      v[BIT_PRESENT] = (pick < 88);
    end else if (2'(lvl) == LVL_PD && pick < 30) begin
      v[BIT_PRESENT] = 1'b1;
      v[BIT_LARGE]   = 1'b1;
    end else if (pick < 85) begin
      v[PA_W-1:12]   = PFN_W'($urandom_range(TABLE_WORDS_DEF / 512 - 1));
      v[BIT_PRESENT] = 1'b1;
      if (2'(lvl) == LVL_PD) v[BIT_LARGE] = 1'b0;
    end else if (pick < 93) begin
      v[BIT_PRESENT] = 1'b0;
    end else begin
      // Pointer past the store: just past it, or anywhere in the address space.
      if ($urandom_range(1)) v[PA_W-1:12] = PFN_W'($urandom_range(15, 8));
      v[BIT_PRESENT] = 1'b1;
      if (2'(lvl) == LVL_PD) v[BIT_LARGE] = 1'b0;
    end
    return v;
  endfunction

  // Send one transaction; leave start high so back-to-back items need no
  // second assignment in the same step.
  task automatic send_item(input in_item_t item);
    int gap;
    gap = (idle_pct != 0 && $urandom_range(99) < idle_pct) ? $urandom_range(4, 1) : 0;
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start   <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (busy);
    predict(item);
  endtask

  task automatic put_entry(input logic [IDX_W-1:0] idx, input logic [PTE_W-1:0] value);
    send_item(write_item(idx, value));
  endtask

  // Fill any undefined word on the walk path, then send the translate.
  task automatic translate_va(input logic [VA_W-1:0] va);
    out_item_t scratch;
    int        word;
    int        lvl;
    word = walk_table(va, scratch, lvl);
    while (word >= 0) begin
      put_entry(word[IDX_W-1:0], make_entry(lvl));
      word = walk_table(va, scratch, lvl);
    end
    send_item(xlate_item(va));
    last_va = va;
  endtask

  // Drop start, drain outstanding results, then let any write finish.
  task automatic wait_idle();
    @(negedge clk) start <= 1'b0;
    while (expected_xlat.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_root(input logic [PA_W-1:0] base);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= base;
    do @(posedge clk); while (!cfg_ready);
    root_base = base;
    n_roots++;
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  // Root base straight out of reset (zero).
  task automatic test_reset_root();
    translate_va(48'h0000_0000_1234);
    translate_va(48'h0000_0060_5678);
  endtask

  // Hand-built tables at pages 0..3: full 4 KiB walk, 2 MiB page, ignored
  // large bit above level 2, faults at levels 0, 1 and 3 and off the store.
  task automatic test_directed_walks();
    wait_idle();
    set_root(52'h0_0000_0000_0FFF);            // page 0, low bits ignored
    put_entry(12'd0,    64'hFFF0_0000_0000_1081); // flags high, large bit ignored
    put_entry(12'd512,  64'h0000_0000_0000_2081); // second level: still a pointer
    put_entry(12'd1024, 64'h0000_0000_0000_3001);
    put_entry(12'd1536, 64'hFFFF_FFFF_FFFF_FFFF); // leaf with every bit set
    translate_va(48'h0000_0000_0000);
    put_entry(12'd511,  64'h0000_0000_0000_1001);
    put_entry(12'd1023, 64'h0000_0000_0000_2001);
    put_entry(12'd1535, 64'h8000_0000_7FE0_0081); // 2 MiB page
    translate_va(48'hFFFF_FFFF_FFFF);
    put_entry(12'd1535, 64'h0000_0000_0000_3001);
    put_entry(12'd2047, 64'h0000_0000_0000_0000); // leaf not present
    translate_va(48'hFFFF_FFFF_FFFF);
    put_entry(12'd2047, 64'h0000_0000_0000_0001); // leaf frame zero
    translate_va(48'hFFFF_FFFF_FFFF);
    put_entry(12'd1, 64'h0000_0000_0000_0000);   // top level not present
    translate_va(48'h0080_0000_0000);
    put_entry(12'd1, 64'h0000_0000_0000_8001);   // pointer just past the store
    translate_va(48'h0080_0000_0000);
    put_entry(12'd1, 64'h000F_FFFF_FFFF_F001);   // pointer at the top of the space
    translate_va(48'h0080_0000_0000);
    put_entry(12'd517, 64'h7FFF_FFFF_FFFF_FFFE); // second level not present
    translate_va(48'h0001_4000_0000);
  endtask

  // Root at the top of the space, just past the store, and on the last page.
  task automatic test_root_extremes();
    wait_idle();
    set_root({PA_W{1'b1}});
    translate_va(48'h0000_0000_0000);
    wait_idle();
    set_root(52'h0_0000_0000_8000);
    translate_va(48'hFFFF_FFFF_FFFF);
    wait_idle();
    set_root(52'h0_0000_0000_7FFF);
    put_entry(12'd3584, 64'h0000_0000_0000_1001);
    translate_va(48'h0000_0000_0ABC);
    put_entry(12'd4095, 64'h0000_0000_0000_0000);
    translate_va(48'hFF80_0000_0000);
  endtask

  // Random walks over a fresh in-store root, with a little random-write noise.
  task automatic test_random_traffic(input int pct, input int count);
    int               stop_at;
    logic [VA_W-1:0]  va;
    wait_idle();
    idle_pct = pct;
    set_root({PFN_W'($urandom_range(TABLE_WORDS_DEF / 512 - 1)), 12'($urandom)});
    stop_at = n_items + count;
    while (n_items < stop_at) begin
      if ($urandom_range(99) < 10) begin
        put_entry(IDX_W'($urandom), {$urandom, $urandom});
      end else begin
        // Reuse the upper tables of the last walk now and then.
        if ($urandom_range(99) < 30) va = {last_va[VA_W-1:21], 21'($urandom)};
        else va = VA_W'({$urandom, $urandom});
        translate_va(va);
      end
    end
    idle_pct = 0;
  endtask

  // Compare each result strobe with the oldest expected translation.
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid) begin
      if (expected_xlat.size() == 0) begin
        flag_error("unexpected result", 64'(out_data.phys_addr), 64'd0);
      end else begin
        want = expected_xlat.pop_front();
        if (out_data.phys_addr !== want.phys_addr)
          flag_error("phys_addr", 64'(out_data.phys_addr), 64'(want.phys_addr));
        if (out_data.valid_res !== want.valid_res)
          flag_error("valid_res", 64'(out_data.valid_res), 64'(want.valid_res));
        if (out_data.large_page !== want.large_page)
          flag_error("large_page", 64'(out_data.large_page), 64'(want.large_page));
      end
    end
  end

  // Abort when nothing moves on any channel for too long.
  always @(posedge clk) begin : watchdog
    int quiet;
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("tb: timeout, %0d results still expected", expected_xlat.size());
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    rst_n     = 1'b0;
    start     = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    root_base = '0;
    idle_pct  = 0;
    errors    = 0;
    last_va   = '0;
    n_items = 0; n_writes = 0; n_mapped = 0; n_large = 0; n_faults = 0; n_roots = 0;
    repeat (4) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    test_reset_root();
    test_directed_walks();
    test_root_extremes();
    test_random_traffic(0, 215);
    test_random_traffic(62, 215);
    test_random_traffic(25, 215);
    wait_idle();

    $display("tb: %0d transactions (%0d table writes) over %0d root settings",
             n_items, n_writes, n_roots);
    $display("tb: walks: %0d on 4 KiB pages, %0d on 2 MiB pages, %0d faults; %0d mismatches",
             n_mapped, n_large, n_faults, errors);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* page_table_walker.f */
design/ptw_pkg.sv
design/ptw_table_mem.sv
design/ptw_walk_ctrl.sv
design/page_table_walker.sv
sim/page_table_walker_test.sv
